FILE: rtl/sync_header_packet_deframer_macros.svh
// Assertion helpers for the deframer RTL.
`ifndef SYNC_HEADER_PACKET_DEFRAMER_MACROS_SVH
`define SYNC_HEADER_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define SHPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shpd assertion failed");

// Next-cycle implication, held off during reset.
`define SHPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shpd assertion failed");

`endif

FILE: rtl/shpd_pkg.sv
package shpd_pkg;

    localparam int COUNT_W = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] MIN_FRAME_BYTES = 17'd8;
    localparam logic [COUNT_W-1:0] HDR_BYTES = 17'd7;
    localparam logic [COUNT_W-1:0] WINDOW_OFS = 17'd6;

    localparam logic [5:0] SYNC_PATTERN_RST = 6'd0;
    localparam logic [7:0] TOL_ERR_RST = 8'hAB;

    // fault codes
    localparam logic [1:0] FAULT_NONE   = 2'd0;
    localparam logic [1:0] FAULT_FORMAT = 2'd1;
    localparam logic [1:0] FAULT_LENGTH = 2'd2;

    // header byte positions
    localparam logic [2:0] POS_SYNC   = 3'd0;
    localparam logic [2:0] POS_ID_HI  = 3'd1;
    localparam logic [2:0] POS_ID_LO  = 3'd2;
    localparam logic [2:0] POS_OPCODE = 3'd3;
    localparam logic [2:0] POS_LEN_HI = 3'd4;
    localparam logic [2:0] POS_LEN_LO = 3'd5;
    localparam logic [2:0] POS_ERROR  = 3'd6;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // decoupling queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = 2;
    localparam logic [Q_AW:0] Q_DEPTH_C = 3'd4;

    // APB
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] ADDR_SYNC_PATTERN = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_TOL_ERR = 3'd4;

    localparam int ODATA_W = 80;

    typedef struct packed {
        logic [5:0] sync_pattern;
        logic [7:0] tolerated_error_code;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  dest_code;
        logic [15:0] packet_id;
        logic [7:0]  opcode_value;
        logic [15:0] payload_length;
        logic [7:0]  device_error;
        logic [15:0] crc_value;
        logic [1:0]  fault_code;
        logic        frame_ok;
    } t_summary;

    typedef struct packed {
        logic       has_pay;
        logic       has_sum;
        logic [7:0] pay_byte;
        t_summary   summary;
    } t_entry;

    // first member sits highest; tdata packs payload_byte in the low bits
    typedef struct packed {
        logic        frame_ok;
        logic [1:0]  fault_code;
        logic [15:0] crc_value;
        logic [7:0]  device_error;
        logic [15:0] payload_length;
        logic [7:0]  opcode_value;
        logic [15:0] packet_id;
        logic [1:0]  dest_code;
        logic [7:0]  payload_byte;
    } t_odata;

endpackage

FILE: rtl/shpd_front.sv
module shpd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  shpd_pkg::t_cfg       i_cfg,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_frame_end,
    output logic                 o_push,
    output shpd_pkg::t_entry     o_entry
);

    logic [shpd_pkg::COUNT_W-1:0] r_count, n_count;
    logic [7:0]  r_sync, n_sync;
    logic [15:0] r_id, n_id;
    logic [7:0]  r_opcode, n_opcode;
    logic [15:0] r_length, n_length;
    logic [7:0]  r_error, n_error;
    logic [15:0] r_crc, n_crc;

    logic in_header;
    logic in_window;
    logic sync_ok_cur;
    logic sync_ok_new;
    logic fault_fmt;
    logic fault_len;
    logic [1:0] fault;
    logic [shpd_pkg::COUNT_W-1:0] win_end;
    shpd_pkg::t_summary summ;

    assign in_header   = r_count < shpd_pkg::HDR_BYTES;
    assign win_end     = {1'b0, r_length} + shpd_pkg::WINDOW_OFS;
    assign in_window   = !in_header && (r_count < win_end);
    assign sync_ok_cur = r_sync[7:2] == i_cfg.sync_pattern;

    // field captures for this byte
    always_comb begin
        n_sync   = r_sync;
        n_id     = r_id;
        n_opcode = r_opcode;
        n_length = r_length;
        n_error  = r_error;
        n_crc    = r_crc;
        if (in_header) begin
            unique case (r_count[2:0])
                shpd_pkg::POS_SYNC:   n_sync = i_data_byte;
                shpd_pkg::POS_ID_HI:  n_id = {i_data_byte, 8'h00};
                shpd_pkg::POS_ID_LO:  n_id = {r_id[15:8], i_data_byte};
                shpd_pkg::POS_OPCODE: n_opcode = i_data_byte;
                shpd_pkg::POS_LEN_HI: n_length = {i_data_byte, 8'h00};
                shpd_pkg::POS_LEN_LO: n_length = {r_length[15:8], i_data_byte};
                shpd_pkg::POS_ERROR:  n_error = i_data_byte;
                default:              n_error = r_error;
            endcase
        end else if (!in_window) begin
            n_crc = {r_crc[7:0], i_data_byte};
        end
        n_count = (r_count == shpd_pkg::COUNT_MAX) ? r_count
                : r_count + {{(shpd_pkg::COUNT_W-1){1'b0}}, 1'b1};
    end

    // frame summary from the updated state
    assign sync_ok_new = n_sync[7:2] == i_cfg.sync_pattern;
    assign fault_fmt   = (n_count < shpd_pkg::MIN_FRAME_BYTES) || !sync_ok_new;
    assign fault_len   = ((n_count - shpd_pkg::MIN_FRAME_BYTES) != {1'b0, n_length})
                      || (n_length == 16'd0);

    always_comb begin
        priority if (fault_fmt) begin
            fault = shpd_pkg::FAULT_FORMAT;
        end else if (fault_len) begin
            fault = shpd_pkg::FAULT_LENGTH;
        end else begin
            fault = shpd_pkg::FAULT_NONE;
        end
        summ = '0;
        summ.fault_code = fault;
        if (fault != shpd_pkg::FAULT_FORMAT) begin
            summ.dest_code    = n_sync[1:0];
            summ.packet_id    = n_id;
            summ.opcode_value = n_opcode;
        end
        if (fault == shpd_pkg::FAULT_NONE) begin
            summ.payload_length = n_length - 16'd1;
            summ.device_error   = n_error;
            summ.crc_value      = n_crc;
            summ.frame_ok       = (n_error == 8'd0)
                               || (n_error == i_cfg.tolerated_error_code);
        end
    end

    assign o_entry.has_pay  = in_window && sync_ok_cur;
    assign o_entry.has_sum  = i_frame_end;
    assign o_entry.pay_byte = i_data_byte;
    assign o_entry.summary  = summ;
    assign o_push = i_accept && (o_entry.has_pay || o_entry.has_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_frame_end)) begin
            r_count  <= '0;
            r_sync   <= '0;
            r_id     <= '0;
            r_opcode <= '0;
            r_length <= '0;
            r_error  <= '0;
            r_crc    <= '0;
        end else if (i_accept) begin
            r_count  <= n_count;
            r_sync   <= n_sync;
            r_id     <= n_id;
            r_opcode <= n_opcode;
            r_length <= n_length;
            r_error  <= n_error;
            r_crc    <= n_crc;
        end
    end

endmodule

FILE: rtl/shpd_queue.sv
`include "sync_header_packet_deframer_macros.svh"

module shpd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  shpd_pkg::t_entry     i_entry,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output shpd_pkg::t_entry     o_head
);

    shpd_pkg::t_entry r_mem [shpd_pkg::Q_DEPTH];
    logic [shpd_pkg::Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [shpd_pkg::Q_AW:0]   r_count;
    logic [shpd_pkg::Q_AW-1:0] ptr_gap;

    assign o_full  = r_count == shpd_pkg::Q_DEPTH_C;
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign ptr_gap = r_wr_ptr - r_rd_ptr;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + {{(shpd_pkg::Q_AW-1){1'b0}}, 1'b1};
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + {{(shpd_pkg::Q_AW-1){1'b0}}, 1'b1};
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + {{shpd_pkg::Q_AW{1'b0}}, 1'b1};
            end else if (i_pop && !i_push) begin
                r_count <= r_count - {{shpd_pkg::Q_AW{1'b0}}, 1'b1};
            end
        end
    end

    `SHPD_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `SHPD_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty)
    `SHPD_ASSERT_IMPL(a_ptr_count, i_clk, i_rst_n, 1'b1, ptr_gap == r_count[shpd_pkg::Q_AW-1:0])

endmodule

FILE: rtl/shpd_back.sv
module shpd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  shpd_pkg::t_entry     i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output shpd_pkg::t_odata     o_data,
    output logic                 o_kind,
    output logic                 o_last
);

    logic r_valid;
    logic r_pay_done, n_pay_done;
    shpd_pkg::t_odata r_data, n_data;
    logic r_kind, n_kind;
    logic load;
    logic emit_pay;

    assign load     = !r_valid || i_ready;
    assign emit_pay = i_head.has_pay && !r_pay_done;

    // payload half goes first; summary half follows on the same entry
    always_comb begin
        n_data = '0;
        n_kind = shpd_pkg::KIND_SUMMARY;
        n_pay_done = r_pay_done;
        o_pop = 1'b0;
        if (emit_pay) begin
            n_data.payload_byte = i_head.pay_byte;
            n_kind = shpd_pkg::KIND_PAYLOAD;
        end else begin
            n_data.dest_code      = i_head.summary.dest_code;
            n_data.packet_id      = i_head.summary.packet_id;
            n_data.opcode_value   = i_head.summary.opcode_value;
            n_data.payload_length = i_head.summary.payload_length;
            n_data.device_error   = i_head.summary.device_error;
            n_data.crc_value      = i_head.summary.crc_value;
            n_data.fault_code     = i_head.summary.fault_code;
            n_data.frame_ok       = i_head.summary.frame_ok;
        end
        if (load && !i_empty) begin
            if (emit_pay && i_head.has_sum) begin
                n_pay_done = 1'b1;
            end else begin
                n_pay_done = 1'b0;
                o_pop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_pay_done <= 1'b0;
        end else if (load) begin
            r_valid    <= !i_empty;
            r_pay_done <= n_pay_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_data <= n_data;
            r_kind <= n_kind;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_kind  = r_kind;
    assign o_last  = r_kind;

endmodule

FILE: rtl/sync_header_packet_deframer.sv
// Sync-header packet deframer. Frame bytes enter on the s_ stream, one item per
// byte, s_tlast on the final byte. Layout: sync byte (top six bits must equal
// the sync_pattern register, low two bits give the destination), 16-bit
// big-endian packet id, opcode, 16-bit big-endian length, error byte,
// length-1 payload bytes, 16-bit big-endian CRC (captured, not checked).
// Payload bytes of a frame with a good sync byte come out as kind-0 items as
// they arrive; the final byte yields one kind-1 summary item (m_tlast high)
// with a fault code: 1 short frame or bad sync, 2 length mismatch or zero
// length. Rate: one input byte per clock while the queue is not full. The front
// end tracks position, captures header fields and writes at most one entry per
// byte into a 4-entry queue; the back end drains one result per cycle, unless
// m_tready stalls it, through a registered output. A frame whose final byte
// lies in the payload window emits two results for that byte, payload first.
// Each result passes through a queue entry and the output register. Registers:
// 0x0 sync_pattern (6 bits, reset 0), 0x4 tolerated_error_code (8 bits, reset
// 0xAB); write only while idle.
module sync_header_packet_deframer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tlast,   // frame_end
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] payload_byte, [9:8] dest_code, [25:10] packet_id,
    // [33:26] opcode_value, [49:34] payload_length, [57:50] device_error,
    // [73:58] crc_value, [75:74] fault_code, [76] frame_ok, [79:77] zero
    output logic [shpd_pkg::ODATA_W-1:0]  m_tdata,
    output logic                          m_tuser,   // result_kind
    output logic                          m_tlast,   // is_last
    // APB config
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [shpd_pkg::APB_AW-1:0]   paddr,
    input  logic [shpd_pkg::APB_DW-1:0]   pwdata,
    output logic [shpd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    shpd_pkg::t_cfg   r_cfg;
    shpd_pkg::t_entry front_entry;
    shpd_pkg::t_entry q_head;
    shpd_pkg::t_odata back_data;
    logic in_accept;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    logic cfg_wr;

    // ---- config registers ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_pattern         <= shpd_pkg::SYNC_PATTERN_RST;
            r_cfg.tolerated_error_code <= shpd_pkg::TOL_ERR_RST;
        end else if (cfg_wr) begin
            // decode on the full byte address; other addresses land on nothing
            if (paddr == shpd_pkg::ADDR_SYNC_PATTERN) begin
                r_cfg.sync_pattern <= pwdata[5:0];
            end else if (paddr == shpd_pkg::ADDR_TOL_ERR) begin
                r_cfg.tolerated_error_code <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == shpd_pkg::ADDR_SYNC_PATTERN) begin
            prdata = {26'd0, r_cfg.sync_pattern};
        end else if (paddr == shpd_pkg::ADDR_TOL_ERR) begin
            prdata = {24'd0, r_cfg.tolerated_error_code};
        end
    end

    // ---- front: classify and capture ----
    // one slot of headroom is all the front needs; it writes at most one entry per accepted byte
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    shpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (in_accept),
        .i_data_byte (s_tdata),
        .i_frame_end (s_tlast),
        .o_push      (push),
        .o_entry     (front_entry)
    );

    // ---- queue between front and back ----
    shpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // ---- back: expand entries into result items ----
    shpd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (q_head),
        .o_pop   (pop),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_data  (back_data),
        .o_kind  (m_tuser),
        .o_last  (m_tlast)
    );

    assign m_tdata = {3'b000, back_data};

endmodule

FILE: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One output item, unpacked into its fields.
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload;
        logic [1:0]  dest;
        logic [15:0] pkt_id;
        logic [7:0]  opcode;
        logic [15:0] pay_len;
        logic [7:0]  dev_err;
        logic [15:0] crc;
        logic [1:0]  fault;
        logic        ok;
        logic        last;
    } t_frame_result;

    // Deframer predictor plus the queue of output items it expects.
    class deframe_scoreboard;
        logic [5:0]  sync_pat;
        logic [7:0]  tol_err;
        logic [16:0] byte_cnt;
        logic [7:0]  hdr_sync;
        logic [15:0] hdr_id;
        logic [7:0]  hdr_opcode;
        logic [15:0] hdr_len;
        logic [7:0]  hdr_err;
        logic [15:0] crc_shift;
        t_frame_result expected_q[$];
        int mismatches;
        int frames;
        int good_frames;
        int format_faults;
        int length_faults;
        int payload_items;

        function new();
            sync_pat = shpd_pkg::SYNC_PATTERN_RST;
            tol_err = shpd_pkg::TOL_ERR_RST;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_cnt = '0;
            hdr_sync = '0;
            hdr_id = '0;
            hdr_opcode = '0;
            hdr_len = '0;
            hdr_err = '0;
            crc_shift = '0;
        endfunction

        function bit sync_matches();
            return hdr_sync[7:2] == sync_pat;
        endfunction

        function void write_reg(logic [shpd_pkg::APB_AW-1:0] addr,
                                logic [shpd_pkg::APB_DW-1:0] data);
            if (addr == shpd_pkg::ADDR_SYNC_PATTERN) begin
                sync_pat = data[5:0];
            end else if (addr == shpd_pkg::ADDR_TOL_ERR) begin
                tol_err = data[7:0];
            end
        endfunction

        // Called once per accepted input byte.
        function void note_byte(logic [7:0] b, logic last);
            t_frame_result r;
            logic [1:0] fault;
            int pos;
            pos = int'(byte_cnt);
            if (byte_cnt < shpd_pkg::HDR_BYTES) begin
                case (byte_cnt[2:0])
                    shpd_pkg::POS_SYNC:   hdr_sync = b;
                    shpd_pkg::POS_ID_HI:  hdr_id = {b, 8'h00};
                    shpd_pkg::POS_ID_LO:  hdr_id[7:0] = b;
                    shpd_pkg::POS_OPCODE: hdr_opcode = b;
                    shpd_pkg::POS_LEN_HI: hdr_len = {b, 8'h00};
                    shpd_pkg::POS_LEN_LO: hdr_len[7:0] = b;
                    shpd_pkg::POS_ERROR:  hdr_err = b;
                    default: ;
                endcase
            end else if (pos < int'(shpd_pkg::WINDOW_OFS) + int'(hdr_len)) begin
                // payload passes through even if the frame faults later
                if (sync_matches()) begin
                    r = '0;
                    r.kind = shpd_pkg::KIND_PAYLOAD;
                    r.payload = b;
                    expected_q.push_back(r);
                    payload_items++;
                end
            end else begin
                crc_shift = {crc_shift[7:0], b};
            end
            if (byte_cnt != shpd_pkg::COUNT_MAX) begin
                byte_cnt++;
            end
            if (last) begin
                r = '0;
                r.kind = shpd_pkg::KIND_SUMMARY;
                r.last = 1'b1;
                if (byte_cnt < shpd_pkg::MIN_FRAME_BYTES || !sync_matches()) begin
                    fault = shpd_pkg::FAULT_FORMAT;
                    format_faults++;
                end else if (byte_cnt - shpd_pkg::MIN_FRAME_BYTES != {1'b0, hdr_len}
                             || hdr_len == 16'd0) begin
                    fault = shpd_pkg::FAULT_LENGTH;
                    length_faults++;
                end else begin
                    fault = shpd_pkg::FAULT_NONE;
                end
                if (fault != shpd_pkg::FAULT_FORMAT) begin
                    r.dest = hdr_sync[1:0];
                    r.pkt_id = hdr_id;
                    r.opcode = hdr_opcode;
                end
                if (fault == shpd_pkg::FAULT_NONE) begin
                    r.pay_len = hdr_len - 16'd1;
                    r.dev_err = hdr_err;
                    r.crc = crc_shift;
                    r.ok = (hdr_err == 8'h00 || hdr_err == tol_err);
                    if (r.ok) begin
                        good_frames++;
                    end
                end
                r.fault = fault;
                expected_q.push_back(r);
                frames++;
                clear_frame();
            end
        endfunction

        function void check_field(string name, int unsigned want, int unsigned seen);
            if (want != seen) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
                mismatches++;
            end
        endfunction

        function void check_result(t_frame_result got);
            t_frame_result want;
            if (expected_q.size() == 0) begin
                $error("result_kind: expected no item, got 0x%0h", got.kind);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            check_field("result_kind", want.kind, got.kind);
            check_field("payload_byte", want.payload, got.payload);
            check_field("dest_code", want.dest, got.dest);
            check_field("packet_id", want.pkt_id, got.pkt_id);
            check_field("opcode_value", want.opcode, got.opcode);
            check_field("payload_length", want.pay_len, got.pay_len);
            check_field("device_error", want.dev_err, got.dev_err);
            check_field("crc_value", want.crc, got.crc);
            check_field("fault_code", want.fault, got.fault);
            check_field("frame_ok", want.ok, got.ok);
            check_field("is_last", want.last, got.last);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    wire                  s_tready;
    logic [7:0]           s_tdata = '0;   // [7:0] data_byte
    logic                 s_tlast = 1'b0; // frame_end
    wire                  m_tvalid;
    logic                 m_tready = 1'b0;
    // [7:0] payload_byte, [9:8] dest_code, [25:10] packet_id, [33:26] opcode_value,
    // [49:34] payload_length, [57:50] device_error, [73:58] crc_value,
    // [75:74] fault_code, [76] frame_ok
    wire [shpd_pkg::ODATA_W-1:0] m_tdata;
    wire                  m_tuser;        // result_kind
    wire                  m_tlast;        // is_last
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [shpd_pkg::APB_AW-1:0] paddr = '0;
    logic [shpd_pkg::APB_DW-1:0] pwdata = '0;
    wire  [shpd_pkg::APB_DW-1:0] prdata;
    wire                  pready;

    deframe_scoreboard sb = new();

    logic [7:0] frame_buf[$];  // bytes of the frame about to be sent
    int  sent_items = 0;
    bit  tx_idle = 1'b1;       // sender may insert gaps
    bit  rx_idle = 1'b1;       // receiver may stall
    int  rx_stall = 0;

    sync_header_packet_deframer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or drops items.
    initial begin
        #40ms;
        $display("tb failed");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    // Output side: check every accepted item, then pick next cycle's tready.
    // Stalls are random in length and can hit any point of a frame.
    always @(posedge i_clk) begin : result_sink
        shpd_pkg::t_odata od;
        t_frame_result    got;
        if (i_rst_n && m_tvalid && m_tready) begin
            od = m_tdata[$bits(shpd_pkg::t_odata)-1:0];
            got.kind = m_tuser;
            got.payload = od.payload_byte;
            got.dest = od.dest_code;
            got.pkt_id = od.packet_id;
            got.opcode = od.opcode_value;
            got.pay_len = od.payload_length;
            got.dev_err = od.device_error;
            got.crc = od.crc_value;
            got.fault = od.fault_code;
            got.ok = od.frame_ok;
            got.last = m_tlast;
            sb.check_result(got);
        end
        if (rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else if (rx_idle && $urandom_range(0, 5) == 0) begin
            rx_stall = pick_gap() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offer one byte, wait for the handshake, then tell the predictor.
    // tvalid stays high into the next item unless a gap is inserted, so it
    // never gets two assignments in one step.
    task automatic push_byte(input logic [7:0] b, input logic last);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge i_clk); while (!s_tready);
        sb.note_byte(b, last);
        sent_items++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++) begin
            push_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    // Header fields as given, then body_n random bytes (payload, CRC, extras).
    task automatic build_frame(input logic [7:0] sync_b, input logic [15:0] pkt_id,
                               input logic [7:0] opc, input logic [15:0] len_f,
                               input logic [7:0] err_b, input int body_n);
        frame_buf.delete();
        frame_buf.push_back(sync_b);
        frame_buf.push_back(pkt_id[15:8]);
        frame_buf.push_back(pkt_id[7:0]);
        frame_buf.push_back(opc);
        frame_buf.push_back(len_f[15:8]);
        frame_buf.push_back(len_f[7:0]);
        frame_buf.push_back(err_b);
        repeat (body_n) frame_buf.push_back(8'($urandom));
    endtask

    // Mostly well-formed frames with random content; the rest are the
    // broken kinds the header checks must catch, plus plain noise.
    task automatic gen_random_frame();
        int sel;
        int len_n;
        int body_n;
        logic [7:0] sync_b;
        logic [7:0] err_b;
        sel = $urandom_range(0, 99);
        len_n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        sync_b = {sb.sync_pat, 2'($urandom_range(0, 3))};
        case ($urandom_range(0, 2))
            0:       err_b = 8'h00;
            1:       err_b = sb.tol_err;
            default: err_b = 8'($urandom);
        endcase
        body_n = len_n + 1;
        tx_idle = $urandom_range(0, 5) != 0;
        rx_idle = $urandom_range(0, 5) != 0;
        if (sel < 64) begin
            // well-formed, body already sized
        end else if (sel < 71) begin
            sync_b[7:2] = sb.sync_pat ^ 6'($urandom_range(1, 63));
        end else if (sel < 79) begin
            // byte count off from the length field, either way
            if ($urandom_range(0, 1) == 1) begin
                body_n = body_n + $urandom_range(1, 3);
            end else begin
                body_n = body_n - $urandom_range(1, len_n);
            end
        end else if (sel < 84) begin
            len_n = 0;
            body_n = $urandom_range(0, 3);
        end else if (sel < 91) begin
            // frame ends while still inside the payload window
            len_n = $urandom_range(3, 20);
            body_n = $urandom_range(1, len_n - 1);
        end
        build_frame(sync_b, 16'($urandom), 8'($urandom), 16'(len_n), err_b, body_n);
        if (sel >= 96) begin
            frame_buf.delete();
            repeat ($urandom_range(1, 20)) frame_buf.push_back(8'($urandom));
        end else if (sel >= 91) begin
            body_n = $urandom_range(1, 7);
            while (frame_buf.size() > body_n) frame_buf.pop_back();
        end
        send_frame();
    endtask

    // APB write: setup phase, access phase, then an idle phase.
    task automatic apb_write(input logic [shpd_pkg::APB_AW-1:0] addr,
                             input logic [shpd_pkg::APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_reg(addr, data);
        @(posedge i_clk);
    endtask

    // Hold the sender until every expected item is out, then let the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [5:0] pat;
        logic [7:0] tol;
        int target;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset settings (pattern 0, tolerated 0xAB).
        // Single-byte frame: too short.
        frame_buf.delete();
        frame_buf.push_back(8'hFF);
        send_frame();
        // Sync bits all ones against pattern zero: bad sync, no payload out.
        build_frame(8'hFC, 16'h1234, 8'h5A, 16'd1, 8'h00, 1);
        send_frame();
        // Max header fields, last byte falls in the payload window: two items.
        build_frame(8'h01, 16'hFFFF, 8'hFF, 16'hFFFF, shpd_pkg::TOL_ERR_RST, 1);
        send_frame();
        // Clean minimal frame, zero header fields and zero error byte.
        build_frame(8'h00, 16'h0000, 8'h00, 16'd1, 8'h00, 2);
        send_frame();
        // Zero length field with a matching byte count.
        build_frame(8'h03, 16'($urandom), 8'($urandom), 16'd0, 8'h55, 1);
        send_frame();
        drain();

        // One long clean frame with no gaps on either side.
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        build_frame({sb.sync_pat, 2'b10}, 16'($urandom), 8'($urandom), 16'd200,
                    shpd_pkg::TOL_ERR_RST, 201);
        send_frame();
        drain();

        // Random frames over six register settings, extremes included.
        // Registers change only after the block has fully drained.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                case (ph)
                    1: begin
                        pat = 6'h3F;
                        tol = 8'h00;
                    end
                    2: begin
                        pat = 6'($urandom);
                        tol = 8'hFF;
                    end
                    3: begin
                        pat = 6'h00;
                        tol = 8'($urandom);
                    end
                    4: begin
                        pat = 6'($urandom);
                        tol = 8'($urandom);
                    end
                    default: begin
                        pat = 6'h3F;
                        tol = shpd_pkg::TOL_ERR_RST;
                    end
                endcase
                apb_write(shpd_pkg::ADDR_SYNC_PATTERN, {26'($urandom), pat});
                apb_write(shpd_pkg::ADDR_TOL_ERR, {24'($urandom), tol});
            end
            target = sent_items + 240;
            while (sent_items < target) gen_random_frame();
            drain();
        end

        $display("deframer: %0d bytes in, %0d frames (%0d ok, %0d format faults, %0d length faults)",
                 sent_items, sb.frames, sb.good_frames, sb.format_faults, sb.length_faults);
        $display("deframer: %0d payload items, six register settings, one long full-rate frame",
                 sb.payload_items);
        if (sb.mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
